@@ design/lbrs_pkg.sv @@
`timescale 1ns / 1ps

package lbrs_pkg;

  // Phase and action codes share one encoding
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_PROBE = 3'd1;
  localparam logic [2:0] PH_MODE  = 3'd2;
  localparam logic [2:0] PH_JOIN  = 3'd3;
  localparam logic [2:0] PH_WAIT  = 3'd4;
  localparam logic [2:0] PH_CLOSE = 3'd5;
  localparam logic [2:0] PH_OPEN  = 3'd6;
  localparam logic [2:0] PH_LOGIN = 3'd7;

  // Input word kinds
  localparam logic KIND_STEP  = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JOIN_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOGIN_LIMIT = 3'd5;

  // Configuration reset values
  localparam logic [15:0] MIN_GAP_RST     = 16'd100;
  localparam logic [3:0]  PROBE_LIMIT_RST = 4'd5;
  localparam logic [3:0]  MODE_LIMIT_RST  = 4'd10;
  localparam logic [3:0]  JOIN_LIMIT_RST  = 4'd10;
  localparam logic [3:0]  OPEN_LIMIT_RST  = 4'd5;
  localparam logic [3:0]  LOGIN_LIMIT_RST = 4'd3;

  typedef struct packed {
    logic        kind;
    logic [31:0] now_ms;
    logic        outcome_ok;
    logic        link_ok;
    logic        sent_before;
  } lbrs_in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic        modem_reset;
    logic [2:0]  phase;
    logic        wifi_up;
    logic        cloud_up;
    logic        busy_res;
    logic [3:0]  retries;
    logic [31:0] reconnects;
    logic [31:0] errors;
  } lbrs_out_t;

  typedef struct packed {
    logic [15:0] min_gap_ms;
    logic [3:0]  probe_retry_limit;
    logic [3:0]  mode_retry_limit;
    logic [3:0]  join_retry_limit;
    logic [3:0]  open_retry_limit;
    logic [3:0]  login_retry_limit;
  } lbrs_cfg_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [3:0]  retry;
    logic [31:0] last_ms;
    logic        busy;
    logic        wifi;
    logic        cloud;
    logic [31:0] reconnects;
    logic [31:0] errors;
  } lbrs_state_t;

endpackage

@@ design/lbrs_cfg.sv @@
`timescale 1ns / 1ps

module lbrs_cfg
  import lbrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output lbrs_cfg_t             cfg
);

  lbrs_cfg_t cfg_r;
  lbrs_cfg_t cfg_nxt;

  // Decode the register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_GAP:     cfg_nxt.min_gap_ms        = cfg_wdata;
        REG_PROBE_LIMIT: cfg_nxt.probe_retry_limit = cfg_wdata[3:0];
        REG_MODE_LIMIT:  cfg_nxt.mode_retry_limit  = cfg_wdata[3:0];
        REG_JOIN_LIMIT:  cfg_nxt.join_retry_limit  = cfg_wdata[3:0];
        REG_OPEN_LIMIT:  cfg_nxt.open_retry_limit  = cfg_wdata[3:0];
        REG_LOGIN_LIMIT: cfg_nxt.login_retry_limit = cfg_wdata[3:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_gap_ms        <= MIN_GAP_RST;
      cfg_r.probe_retry_limit <= PROBE_LIMIT_RST;
      cfg_r.mode_retry_limit  <= MODE_LIMIT_RST;
      cfg_r.join_retry_limit  <= JOIN_LIMIT_RST;
      cfg_r.open_retry_limit  <= OPEN_LIMIT_RST;
      cfg_r.login_retry_limit <= LOGIN_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/lbrs_step.sv @@
`timescale 1ns / 1ps

module lbrs_step
  import lbrs_pkg::*;
(
  input  lbrs_cfg_t   cfg,
  input  lbrs_state_t st,
  input  lbrs_in_t    item,
  output lbrs_state_t st_nxt,
  output lbrs_out_t   res
);

  logic [31:0] gap;
  logic        step_go;
  logic [3:0]  lim;
  logic [4:0]  fail_cnt;
  logic        past_lim;
  logic [2:0]  action;
  logic        mreset;

  // Pick the retry limit of the current phase
  always_comb begin
    unique case (st.phase)
      PH_PROBE: lim = cfg.probe_retry_limit;
      PH_MODE:  lim = cfg.mode_retry_limit;
      PH_JOIN:  lim = cfg.join_retry_limit;
      PH_OPEN:  lim = cfg.open_retry_limit;
      PH_LOGIN: lim = cfg.login_retry_limit;
      default:  lim = 4'd0;
    endcase
  end

  // Count one failure in five bits so the count never wraps
  assign fail_cnt = {1'b0, st.retry} + 5'd1;
  assign past_lim = fail_cnt > {1'b0, lim};

  // Gate steps on busy and the minimum gap since the last action
  assign gap     = item.now_ms - st.last_ms;
  assign step_go = st.busy && (gap >= 32'(cfg.min_gap_ms));

  always_comb begin
    st_nxt = st;
    action = PH_IDLE;
    mreset = 1'b0;
    if (item.kind == KIND_STEP) begin
      if (step_go) begin
        if (st.phase != PH_IDLE) begin
          action         = st.phase;
          st_nxt.last_ms = item.now_ms;
        end
        unique case (st.phase) inside
          PH_IDLE: begin
            st_nxt.busy = 1'b0;
          end
          PH_PROBE, PH_MODE, PH_JOIN: begin
            if (item.outcome_ok) begin
              if (st.phase == PH_JOIN) st_nxt.wifi = 1'b1;
              st_nxt.phase = 3'(st.phase + 3'd1);
              st_nxt.retry = 4'd0;
            end else if (past_lim) begin
              st_nxt.retry = 4'd0;
              st_nxt.phase = PH_PROBE;
              mreset       = 1'b1;
            end else begin
              st_nxt.retry = fail_cnt[3:0];
            end
          end
          PH_WAIT: begin
            st_nxt.phase = PH_CLOSE;
          end
          PH_CLOSE: begin
            st_nxt.phase = PH_OPEN;
          end
          PH_OPEN: begin
            if (item.outcome_ok) begin
              st_nxt.phase = PH_LOGIN;
              st_nxt.retry = 4'd0;
            end else if (past_lim) begin
              st_nxt.retry = 4'd0;
              st_nxt.phase = PH_JOIN;
            end else begin
              st_nxt.retry = fail_cnt[3:0];
            end
          end
          default: begin
            // login
            if (item.outcome_ok) begin
              st_nxt.cloud = 1'b1;
              st_nxt.busy  = 1'b0;
              st_nxt.phase = PH_IDLE;
              if ((st.reconnects != 32'd0) || item.sent_before) begin
                st_nxt.reconnects = st.reconnects + 32'd1;
              end
            end else if (past_lim) begin
              st_nxt.retry = 4'd0;
              st_nxt.phase = PH_CLOSE;
            end else begin
              st_nxt.retry = fail_cnt[3:0];
            end
          end
        endcase
      end
    end else begin
      // Link check: drop the link on loss, then restart where needed
      if (st.wifi && !st.busy && !item.link_ok) begin
        st_nxt.wifi   = 1'b0;
        st_nxt.cloud  = 1'b0;
        st_nxt.phase  = PH_PROBE;
        st_nxt.busy   = 1'b1;
        st_nxt.retry  = 4'd0;
        st_nxt.errors = st.errors + 32'd1;
      end
      if (!st_nxt.wifi && !st_nxt.busy) begin
        st_nxt.phase = PH_PROBE;
        st_nxt.busy  = 1'b1;
        st_nxt.retry = 4'd0;
      end
      if (st_nxt.wifi && !st_nxt.cloud && !st_nxt.busy) begin
        st_nxt.phase = PH_CLOSE;
        st_nxt.busy  = 1'b1;
        st_nxt.retry = 4'd0;
      end
    end
  end

  // Build the result word from the updated state
  always_comb begin
    res.action      = action;
    res.modem_reset = mreset;
    res.phase       = st_nxt.phase;
    res.wifi_up     = st_nxt.wifi;
    res.cloud_up    = st_nxt.cloud;
    res.busy_res    = st_nxt.busy;
    res.retries     = st_nxt.retry;
    res.reconnects  = st_nxt.reconnects;
    res.errors      = st_nxt.errors;
  end

endmodule

@@ design/link_bringup_retry_sequencer.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Word
// in_       input      in_valid / in_stall   lbrs_in_t  (step or link check)
// out_      output     out_valid / out_stall lbrs_out_t (one result per word)
// cfg_      input      cfg_we               index + 16-bit data, no read-back
//
// Each input word is registered, evaluated combinationally against the sequencer
// state and lands in the result register: one word per cycle sustained while the
// result is not stalled. The single state update per cycle sets this rate.
// Reset (rst_n low, synchronous) starts bring-up at probe with all counters zero.
// A stalled result holds; the input register keeps accepting as long as the
// result register is empty or being drained.

module link_bringup_retry_sequencer
  import lbrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lbrs_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lbrs_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  lbrs_cfg_t   cfg;
  lbrs_state_t state_r;
  lbrs_state_t state_nxt;
  lbrs_in_t    in_data_r;
  logic        in_valid_r;
  lbrs_out_t   out_data_r;
  logic        out_valid_r;
  lbrs_out_t   res;
  logic        advance;

  lbrs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lbrs_step u_step (
    .cfg    (cfg),
    .st     (state_r),
    .item   (in_data_r),
    .st_nxt (state_nxt),
    .res    (res)
  );

  // Advance the held word when the result register can take it
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase      <= PH_PROBE;
      state_r.retry      <= 4'd0;
      state_r.last_ms    <= 32'd0;
      state_r.busy       <= 1'b1;
      state_r.wifi       <= 1'b0;
      state_r.cloud      <= 1'b0;
      state_r.reconnects <= 32'd0;
      state_r.errors     <= 32'd0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // Idle only once fully logged in
  assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.busy |-> (state_r.phase == PH_IDLE) && state_r.wifi && state_r.cloud)
    else $error("sequencer idle without a complete link");

  // An issued action is always the phase held before the word
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && (res.action != PH_IDLE) |-> res.action == state_r.phase)
    else $error("action does not match current phase");

  // A modem reset restarts at probe with a cleared count
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.modem_reset |->
      (out_data_r.phase == PH_PROBE) && (out_data_r.retries == 4'd0))
    else $error("modem reset without restart at probe");

  // Error count moves by at most one per word
  assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (state_r.errors == $past(state_r.errors)) ||
                (state_r.errors == $past(state_r.errors) + 32'd1))
    else $error("error count jumped");
`endif

endmodule

@@ dv/lbrs_checker.sv @@
`timescale 1ns / 1ps

module lbrs_checker
  import lbrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  lbrs_in_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  lbrs_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    compared,
  output int                    modem_resets,
  output int                    logins
);

  localparam int MAX_REPORTS = 10;

  // Register copies
  logic [15:0] gap_cfg;
  logic [3:0]  probe_lim;
  logic [3:0]  mode_lim;
  logic [3:0]  join_lim;
  logic [3:0]  open_lim;
  logic [3:0]  login_lim;

  // Sequencer copy
  logic [2:0]  seq_phase;
  logic [3:0]  seq_retry;
  logic [31:0] last_issue_ms;
  logic        seq_busy;
  logic        wifi_joined;
  logic        cloud_logged;
  logic [31:0] reconnect_cnt;
  logic [31:0] error_cnt;

  lbrs_out_t predicted_status[$];

  // Count one failure; true once the count goes past the limit (count cleared)
  function automatic bit retry_exhausted(logic [3:0] limit);
    logic [4:0] tries;
    tries = {1'b0, seq_retry} + 5'd1;
    if (tries > {1'b0, limit}) begin
      seq_retry = '0;
      return 1'b1;
    end
    seq_retry = tries[3:0];
    return 1'b0;
  endfunction

  function automatic void restart_from(logic [2:0] ph);
    seq_phase = ph;
    seq_busy  = 1'b1;
    seq_retry = '0;
  endfunction

  // Apply one input word to the sequencer copy and return the status it yields
  function automatic lbrs_out_t advance_sequencer(lbrs_in_t w);
    lbrs_out_t   r;
    logic [2:0]  issued;
    logic        reset_modem;
    logic [31:0] elapsed;
    logic [3:0]  lim;
    issued      = PH_IDLE;
    reset_modem = 1'b0;
    elapsed     = w.now_ms - last_issue_ms;
    if (w.kind == KIND_STEP) begin
      if (seq_busy && elapsed >= {16'd0, gap_cfg}) begin
        if (seq_phase == PH_IDLE) begin
          seq_busy = 1'b0;
        end else begin
          issued        = seq_phase;
          last_issue_ms = w.now_ms;
          case (seq_phase) inside
            PH_PROBE, PH_MODE, PH_JOIN: begin
              if (w.outcome_ok) begin
                if (seq_phase == PH_JOIN) wifi_joined = 1'b1;
                seq_phase = seq_phase + 3'd1;
                seq_retry = '0;
              end else begin
                lim = (seq_phase == PH_PROBE) ? probe_lim :
                      (seq_phase == PH_MODE)  ? mode_lim  : join_lim;
                if (retry_exhausted(lim)) begin
                  reset_modem = 1'b1;
                  seq_phase   = PH_PROBE;
                end
              end
            end
            PH_WAIT:  seq_phase = PH_CLOSE;
            PH_CLOSE: seq_phase = PH_OPEN;
            PH_OPEN: begin
              if (w.outcome_ok) begin
                seq_phase = PH_LOGIN;
                seq_retry = '0;
              end else if (retry_exhausted(open_lim)) begin
                seq_phase = PH_JOIN;
              end
            end
            default: begin
              if (w.outcome_ok) begin
                cloud_logged = 1'b1;
                seq_busy     = 1'b0;
                seq_phase    = PH_IDLE;
                logins++;
                if (reconnect_cnt != '0 || w.sent_before)
                  reconnect_cnt = reconnect_cnt + 32'd1;
              end else if (retry_exhausted(login_lim)) begin
                seq_phase = PH_CLOSE;
              end
            end
          endcase
        end
      end
    end else begin
      // Link check rules, in order
      if (wifi_joined && !seq_busy && !w.link_ok) begin
        wifi_joined  = 1'b0;
        cloud_logged = 1'b0;
        restart_from(PH_PROBE);
        error_cnt = error_cnt + 32'd1;
      end
      if (!wifi_joined && !seq_busy) restart_from(PH_PROBE);
      if (wifi_joined && !cloud_logged && !seq_busy) restart_from(PH_CLOSE);
    end
    if (reset_modem) modem_resets++;
    r.action      = issued;
    r.modem_reset = reset_modem;
    r.phase       = seq_phase;
    r.wifi_up     = wifi_joined;
    r.cloud_up    = cloud_logged;
    r.busy_res    = seq_busy;
    r.retries     = seq_retry;
    r.reconnects  = reconnect_cnt;
    r.errors      = error_cnt;
    return r;
  endfunction

  function automatic string status_text(lbrs_out_t s);
    return $sformatf({"act=%0d mrst=%0b ph=%0d wifi=%0b cloud=%0b busy=%0b",
                      " retry=%0d rec=%0d err=%0d"},
                     s.action, s.modem_reset, s.phase, s.wifi_up, s.cloud_up, s.busy_res,
                     s.retries, s.reconnects, s.errors);
  endfunction

  function automatic void compare_status(lbrs_out_t got, lbrs_out_t want);
    string bad;
    bad = "";
    if (got.action      !== want.action)      bad = {bad, " action"};
    if (got.modem_reset !== want.modem_reset) bad = {bad, " modem_reset"};
    if (got.phase       !== want.phase)       bad = {bad, " phase"};
    if (got.wifi_up     !== want.wifi_up)     bad = {bad, " wifi_up"};
    if (got.cloud_up    !== want.cloud_up)    bad = {bad, " cloud_up"};
    if (got.busy_res    !== want.busy_res)    bad = {bad, " busy_res"};
    if (got.retries     !== want.retries)     bad = {bad, " retries"};
    if (got.reconnects  !== want.reconnects)  bad = {bad, " reconnects"};
    if (got.errors      !== want.errors)      bad = {bad, " errors"};
    if (bad != "") begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("[%0t] status word %0d differs in%s", $realtime, compared, bad);
        $display("  expected %s", status_text(want));
        $display("  actual   %s", status_text(got));
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      gap_cfg       = MIN_GAP_RST;
      probe_lim     = PROBE_LIMIT_RST;
      mode_lim      = MODE_LIMIT_RST;
      join_lim      = JOIN_LIMIT_RST;
      open_lim      = OPEN_LIMIT_RST;
      login_lim     = LOGIN_LIMIT_RST;
      seq_phase     = PH_PROBE;
      seq_retry     = '0;
      last_issue_ms = '0;
      seq_busy      = 1'b1;
      wifi_joined   = 1'b0;
      cloud_logged  = 1'b0;
      reconnect_cnt = '0;
      error_cnt     = '0;
      predicted_status.delete();
    end else begin
      // Retire the oldest expectation on each accepted result
      if (out_valid && !out_stall) begin
        if (predicted_status.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("[%0t] unexpected status word: %s", $realtime, status_text(out_data));
        end else begin
          compare_status(out_data, predicted_status.pop_front());
          compared++;
        end
      end
      // Mirror register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_GAP:     gap_cfg   = cfg_wdata;
          REG_PROBE_LIMIT: probe_lim = cfg_wdata[3:0];
          REG_MODE_LIMIT:  mode_lim  = cfg_wdata[3:0];
          REG_JOIN_LIMIT:  join_lim  = cfg_wdata[3:0];
          REG_OPEN_LIMIT:  open_lim  = cfg_wdata[3:0];
          REG_LOGIN_LIMIT: login_lim = cfg_wdata[3:0];
          default: ;
        endcase
      end
      // Predict on each accepted input word
      if (in_valid && !in_stall)
        predicted_status.push_back(advance_sequencer(in_data));
    end
    pending = predicted_status.size();
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import lbrs_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          PHASE_WORDS = 160;
  localparam int          TAIL_CYCLES = 4;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  lbrs_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  lbrs_out_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_MIN_GAP;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int          mismatches;
  int          pend;
  int          checked;
  int          resets_seen;
  int          logins_seen;

  // Stimulus knobs
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          ok_pct = 50;
  bit          hold_req = 1'b0;
  logic [31:0] clock_ms = '0;
  logic [15:0] cur_gap = MIN_GAP_RST;
  int          words_sent = 0;
  int          settings_loaded = 0;
  int unsigned cycles = 0;

  link_bringup_retry_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lbrs_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (mismatches),
    .pending      (pend),
    .compared     (checked),
    .modem_resets (resets_seen),
    .logins       (logins_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: one long hold-off on request, random stalls otherwise
  int hold_left = 0;
  bit hold_taken = 1'b0;
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pend);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic lbrs_in_t make_word(logic kind, logic [31:0] now, logic ok,
                                         logic link, logic sent);
    lbrs_in_t w;
    w.kind        = kind;
    w.now_ms      = now;
    w.outcome_ok  = ok;
    w.link_ok     = link;
    w.sent_before = sent;
    return w;
  endfunction

  // Mostly timely steps, some early steps, link checks and a little noise
  function automatic lbrs_in_t random_word();
    int       pick;
    lbrs_in_t w;
    pick          = $urandom_range(99);
    w.kind        = KIND_STEP;
    w.outcome_ok  = ($urandom_range(99) < ok_pct);
    w.link_ok     = 1'($urandom_range(1));
    w.sent_before = 1'($urandom_range(1));
    if (pick < 75) begin
      clock_ms = clock_ms + cur_gap + $urandom_range(40);
      w.now_ms = clock_ms;
    end else if (pick < 85) begin
      w.now_ms = clock_ms + $urandom_range(cur_gap);
    end else if (pick < 97) begin
      w.kind   = KIND_CHECK;
      w.now_ms = clock_ms;
    end else begin
      w.kind       = 1'($urandom_range(1));
      w.now_ms     = $urandom();
      w.outcome_ok = 1'($urandom_range(1));
    end
    return w;
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic put_word(input lbrs_in_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Wait until every predicted result has come back
  task automatic drain();
    do @(negedge clk); while (pend != 0);
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] gap, input logic [3:0] lp, lm, lj, lo, ll);
    logic [15:0]          vals [6];
    logic [CFG_IDX_W-1:0] idx [6];
    vals = '{gap, {12'd0, lp}, {12'd0, lm}, {12'd0, lj}, {12'd0, lo}, {12'd0, ll}};
    idx  = '{REG_MIN_GAP, REG_PROBE_LIMIT, REG_MODE_LIMIT, REG_JOIN_LIMIT,
             REG_OPEN_LIMIT, REG_LOGIN_LIMIT};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    cur_gap = gap;
    settings_loaded++;
  endtask

  task automatic run_phase(int n, int s_idle, int r_stall, int okp);
    idle_pct  = s_idle;
    stall_pct <= r_stall;
    ok_pct    = okp;
    repeat (n) put_word(random_word());
    in_valid <= 1'b0;
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed walk with reset settings: gap edges, every phase, checks, time wrap
    put_word(make_word(KIND_STEP,  32'd0,    1'b1, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'd100,  1'b0, 1'b0, 1'b0));
    put_word(make_word(KIND_CHECK, 32'd150,  1'b0, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'd200,  1'b1, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'd300,  1'b1, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'd399,  1'b1, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'd400,  1'b1, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'd500,  1'b0, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'd600,  1'b0, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'd700,  1'b0, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'd800,  1'b1, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'd900,  1'b0, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'd1000, 1'b1, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'd1100, 1'b1, 1'b1, 1'b1));
    put_word(make_word(KIND_CHECK, 32'd1150, 1'b1, 1'b1, 1'b1));
    put_word(make_word(KIND_CHECK, 32'd1200, 1'b0, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
    put_word(make_word(KIND_STEP,  32'h0000_0062, 1'b1, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'h0000_0063, 1'b1, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'h0000_0100, 1'b1, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'h0000_0200, 1'b1, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'h0000_0300, 1'b1, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'h0000_0400, 1'b1, 1'b0, 1'b0));
    put_word(make_word(KIND_STEP,  32'h0000_0500, 1'b1, 1'b0, 1'b1));
    put_word(make_word(KIND_CHECK, 32'h0000_0600, 1'b0, 1'b0, 1'b1));
    in_valid <= 1'b0;
    drain();
    clock_ms = 32'h0000_0600;

    // Zero gap and zero limits: every failure resets or falls back
    load_settings(16'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
    run_phase(PHASE_WORDS, 0, 0, 50);

    // Widest gap and highest limits, mostly failing, sender mostly idle
    clock_ms = 32'hFFF0_0000;
    load_settings(16'hFFFF, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15);
    run_phase(PHASE_WORDS, 85, 0, 10);

    // Random settings, receiver mostly stalling
    load_settings(16'($urandom_range(65535)), 4'($urandom_range(15)),
                  4'($urandom_range(15)), 4'($urandom_range(15)),
                  4'($urandom_range(15)), 4'($urandom_range(15)));
    run_phase(PHASE_WORDS, 0, 85, 70);

    // Back to reset values, light idling on both sides
    load_settings(MIN_GAP_RST, PROBE_LIMIT_RST, MODE_LIMIT_RST, JOIN_LIMIT_RST,
                  OPEN_LIMIT_RST, LOGIN_LIMIT_RST);
    run_phase(PHASE_WORDS, 14, 14, 60);

    // Long receiver hold-off while the sender keeps pushing
    hold_req <= 1'b1;
    load_settings(16'd1, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  4'($urandom_range(15)), 4'($urandom_range(15)),
                  4'($urandom_range(15)));
    run_phase(PHASE_WORDS, 0, 30, 75);

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d words under %0d register settings; %0d status words checked.",
             words_sent, settings_loaded + 1, checked);
    $display("Predicted %0d modem resets and %0d completed logins; %0d mismatches.",
             resets_seen, logins_seen, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
